### hdl/cld_pkg.sv
// Shared types, constants and ring arithmetic for the circular list deque.
// Used by cld_front, cld_back and circular_list_deque.
package cld_pkg;

   localparam int DEPTH       = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_CLEAR      = 3'd4;
   localparam logic [2:0] CMD_READ_ALL   = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_CLEAR,
      OP_READ_ALL
   } op_kind_type;

   typedef struct packed {
      op_kind_type               kind;
      logic signed [VALUE_W-1:0] value;
   } op_type;

   typedef struct packed {
      logic [CNT_W-1:0] occupancy;
      logic [IDX_W-1:0] front;
   } cld_status_type;

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + {1'b0, offset};
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
      logic [IDX_W-1:0] res;
      if (base == '0) begin
         res = IDX_W'(DEPTH - 1);
      end else begin
         res = base - 1'b1;
      end
      return res;
   endfunction

   function automatic logic [COUNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+COUNT_W-1:0] w;
      w = (CNT_W + COUNT_W)'(c);
      return w[COUNT_W-1:0];
   endfunction

endpackage

### hdl/cld_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cld_front.sv
// Command intake: decodes request words into operations and buffers them
// in a short queue ahead of the execution side. Depends on cld_pkg.
module cld_front import cld_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] command
   output logic        op_valid,
   input  logic        op_ready,
   output op_type      op
);

   op_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               cmd_ok;
   op_type             dec_op;
   logic               push, pop;

   always_comb begin
      cmd_ok       = 1'b1;
      dec_op.value = req_tdata[VALUE_W-1:0];
      dec_op.kind  = OP_CLEAR;
      unique case (req_tuser)
         CMD_PUSH_FRONT: dec_op.kind = OP_PUSH_FRONT;
         CMD_PUSH_BACK:  dec_op.kind = OP_PUSH_BACK;
         CMD_POP_FRONT:  dec_op.kind = OP_POP_FRONT;
         CMD_POP_BACK:   dec_op.kind = OP_POP_BACK;
         CMD_CLEAR:      dec_op.kind = OP_CLEAR;
         CMD_READ_ALL:   dec_op.kind = OP_READ_ALL;
         default:        cmd_ok      = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign op_valid   = (count_ff != '0);
   assign op         = queue_ff[rd_ptr_ff];

   // unused command codes are taken and dropped
   assign push = req_tvalid & req_tready & cmd_ok;
   assign pop  = op_valid & op_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec_op;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/cld_back.sv
// Execution side: applies queued operations to the ring store and the
// front/occupancy pointers, drives the result register. Depends on
// cld_pkg and cld_ram.
module cld_back import cld_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           op_valid,
   output logic           op_ready,
   input  op_type         op,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [39:0]    rsp_tdata,   // [31:0] entry_value, [36:32] entry_count, [39:37] zero
   output logic [1:0]     rsp_tuser,   // [1:0] status
   output logic           rsp_tlast,   // last_of_run
   output cld_status_type status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_WALK
   } state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          front_ff, front_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [IDX_W-1:0]          walk_ff, walk_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      out_free;
   logic [CNT_W-1:0]          walk_next;
   logic                      walk_last;
   logic                      wr_en, rd_en;
   logic [IDX_W-1:0]          wr_addr, rd_addr;
   logic [VALUE_W-1:0]        rd_data;

   cld_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(op.value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign walk_next = CNT_W'(walk_ff) + 1'b1;
   assign walk_last = (walk_next == occ_ff);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      walk_in       = walk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      op_ready      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = front_ff;
      rd_en         = 1'b0;
      rd_addr       = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && out_free) begin
               op_ready      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = ST_OK;
               rsp_count_in  = count_out(occ_ff);
               rsp_last_in   = 1'b1;
               unique case (op.kind)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en  = 1'b1;
                        occ_in = occ_ff + 1'b1;
                        if (op.kind == OP_PUSH_FRONT) begin
                           front_in = ring_dec(front_ff);
                           wr_addr  = ring_dec(front_ff);
                        end else begin
                           wr_addr  = ring_add(front_ff, occ_ff);
                        end
                        rsp_count_in = count_out(occ_ff + 1'b1);
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (occ_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        occ_in       = occ_ff - 1'b1;
                        state_in     = S_POP;
                        if (op.kind == OP_POP_FRONT) begin
                           front_in = ring_add(front_ff, CNT_W'(1));
                        end else begin
                           rd_addr  = ring_add(front_ff, occ_ff - 1'b1);
                        end
                     end
                  end
                  OP_CLEAR: begin
                     occ_in       = '0;
                     front_in     = '0;
                     rsp_count_in = '0;
                  end
                  OP_READ_ALL: begin
                     if (occ_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        walk_in      = '0;
                        state_in     = S_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         S_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data;
               rsp_status_in = ST_OK;
               rsp_count_in  = count_out(occ_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_WALK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_data;
               rsp_status_in = ST_OK;
               rsp_count_in  = count_out(occ_ff);
               rsp_last_in   = walk_last;
               if (walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  walk_in = walk_next[IDX_W-1:0];
                  rd_en   = 1'b1;
                  rd_addr = ring_add(front_ff, walk_next);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      walk_ff       <= walk_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = {3'b000, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser        = rsp_status_ff;
   assign rsp_tlast        = rsp_last_ff;
   assign status.occupancy = occ_ff;
   assign status.front     = front_ff;

endmodule

### hdl/circular_list_deque.sv
// Bounded double-ended queue of signed 32-bit entries held in a 16-word ring
// memory. Each request word carries a command in tuser (push front, push back,
// pop front, pop back, clear, read all) and the value to push in tdata; every
// command but the unused codes answers with result words whose tlast marks the
// final one. A command is buffered in a two-deep queue, so requests are taken
// while the execution side is busy; result words leave from registered outputs.
// Pushes, clear and flagged commands are finished in the idle state; a pop
// waits in its own state for a registered store read; read all walks the
// entries, one result word each, bounded by the single store read port.
// Back-to-back pushes run at one word per cycle while the result output is not
// stalled. Full pushes report status 2, pops or read-out of an empty list
// report status 1. Depends on cld_pkg, cld_front, cld_back and cld_ram.
module circular_list_deque import cld_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] entry_value, [36:32] entry_count, [39:37] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last_of_run
);

   logic           op_valid;
   logic           op_ready;
   op_type         op;
   cld_status_type status;

   cld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op        (op)
   );

   cld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op        (op),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .status    (status)
   );

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      status.occupancy <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, status.front} < (IDX_W + 1)'(DEPTH))
      else $error("front index outside ring");

   a_flag_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tlast && rsp_tdata[31:0] == '0)
      else $error("flagged word not single and zero");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> status.occupancy == '0 && !rsp_tvalid)
      else $error("list not empty after reset");
`endif

endmodule

### tb/tb_circular_list_deque.sv
// Self-checking testbench for circular_list_deque: directed and random command
// words drive the stream input, a deque predictor checks every result word.
// Depends on cld_pkg and circular_list_deque.
module tb_circular_list_deque import cld_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] value;
   } cmd_word_type;

   typedef struct packed {
      logic signed [31:0] entry_value;
      logic [1:0]         status;
      logic [4:0]         entry_count;
      logic               last;
   } result_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   cmd_word_type    pending_cmds[$];
   result_word_type expected_words[$];

   // deque predictor state
   logic signed [31:0] ring_model[DEPTH];
   logic [IDX_W-1:0]   front_pos = '0;
   logic [CNT_W-1:0]   occ       = '0;

   int  send_idle_pct  = 0;
   int  rsp_stall_pct  = 0;
   bit  hold_go        = 1'b0;
   bit  hold_rsp       = 1'b0;
   int  mismatches     = 0;

   circular_list_deque u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) begin
         $display("%0t ns: %s", $realtime, msg);
      end
   endtask

   task automatic post_result(input logic signed [31:0] v, input logic [1:0] st,
                              input logic last);
      result_word_type w;
      w.entry_value = v;
      w.status      = st;
      w.entry_count = count_out(occ);
      w.last        = last;
      expected_words.push_back(w);
   endtask

   task automatic predict_deque(input logic [2:0] cmd, input logic signed [31:0] value);
      int pos;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (int'(occ) >= DEPTH) begin
               post_result('0, ST_FULL, 1'b1);
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  front_pos = IDX_W'((int'(front_pos) + DEPTH - 1) % DEPTH);
                  ring_model[front_pos] = value;
               end else begin
                  ring_model[(int'(front_pos) + int'(occ)) % DEPTH] = value;
               end
               occ = occ + 1'b1;
               post_result('0, ST_OK, 1'b1);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (occ == 0) begin
               post_result('0, ST_EMPTY, 1'b1);
            end else begin
               if (cmd == CMD_POP_FRONT) begin
                  pos = int'(front_pos);
                  front_pos = IDX_W'((int'(front_pos) + 1) % DEPTH);
               end else begin
                  pos = (int'(front_pos) + int'(occ) - 1) % DEPTH;
               end
               occ = occ - 1'b1;
               post_result(ring_model[pos], ST_OK, 1'b1);
            end
         end
         CMD_CLEAR: begin
            occ = '0;
            front_pos = '0;
            post_result('0, ST_OK, 1'b1);
         end
         CMD_READ_ALL: begin
            if (occ == 0) begin
               post_result('0, ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < int'(occ); i++) begin
                  post_result(ring_model[(int'(front_pos) + i) % DEPTH], ST_OK,
                              i + 1 == int'(occ));
               end
            end
         end
         default: ;
      endcase
   endtask

   // driver: predicts on each accepted word, then offers the next one
   always @(posedge clock) begin : drv
      cmd_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_deque(req_tuser, req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.cmd;
               req_tdata  <= nxt.value;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // long receiver hold-off, counted here
   initial begin
      wait (hold_go);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   always @(posedge clock) begin : mon
      result_word_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", rsp_tdata));
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_tdata[31:0] !== exp_w.entry_value) begin
               report_mismatch($sformatf("entry_value %h, want %h",
                                         rsp_tdata[31:0], exp_w.entry_value));
            end
            if (rsp_tuser !== exp_w.status) begin
               report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, exp_w.status));
            end
            if (rsp_tdata[36:32] !== exp_w.entry_count) begin
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         rsp_tdata[36:32], exp_w.entry_count));
            end
            if (rsp_tlast !== exp_w.last) begin
               report_mismatch($sformatf("tlast %b, want %b", rsp_tlast, exp_w.last));
            end
         end
      end
   end

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      case ($urandom_range(7))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7FFF_FFFF;
         2:       v = 32'h0000_0000;
         3:       v = 32'hFFFF_FFFF;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic queue_cmd(input logic [2:0] cmd, input logic [31:0] value);
      cmd_word_type w;
      w.cmd   = cmd;
      w.value = value;
      pending_cmds.push_back(w);
   endtask

   // push_pct steers the fill level: high values reach full, low values empty
   task automatic queue_random(input int count, input int push_pct);
      int done;
      int r;
      done = 0;
      while (done < count) begin
         r = $urandom_range(99);
         if (r < 3) begin
            queue_cmd($urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO, $urandom);
         end else begin
            done++;
            if (r < 6) begin
               queue_cmd(CMD_CLEAR, $urandom);
            end else if (r < 14) begin
               queue_cmd(CMD_READ_ALL, $urandom);
            end else if (r < 14 + push_pct) begin
               queue_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
            end else begin
               queue_cmd($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom);
            end
         end
      end
   endtask

   task automatic drain_all();
      while (pending_cmds.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list, single entry, both ends, ignored codes
      queue_cmd(CMD_POP_FRONT, 32'h1234_5678);
      queue_cmd(CMD_POP_BACK, 32'hFFFF_FFFF);
      queue_cmd(CMD_READ_ALL, 32'h0);
      queue_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
      queue_cmd(CMD_PUSH_BACK, 32'h8000_0000);
      queue_cmd(CMD_READ_ALL, 32'h0);
      queue_cmd(CMD_POP_BACK, 32'h0);
      queue_cmd(CMD_POP_FRONT, 32'h0);
      queue_cmd(CMD_UNUSED_LO, 32'hFFFF_FFFF);
      queue_cmd(CMD_UNUSED_HI, 32'h0);
      // fill to full, then refused pushes at both ends
      for (int i = 0; i < DEPTH; i++) begin
         queue_cmd(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
      end
      queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      queue_cmd(CMD_PUSH_BACK, 32'h0);
      queue_cmd(CMD_READ_ALL, 32'h0);
      queue_cmd(CMD_CLEAR, 32'hFFFF_FFFF);
      drain_all();

      queue_random(60, 60);
      drain_all();

      send_idle_pct <= 45;
      queue_random(60, 35);
      drain_all();

      send_idle_pct <= 0;
      rsp_stall_pct <= 45;
      queue_random(60, 55);
      drain_all();

      send_idle_pct <= 26;
      rsp_stall_pct <= 26;
      queue_random(60, 45);
      drain_all();

      // receiver holds off while the sender keeps offering
      send_idle_pct <= 0;
      rsp_stall_pct <= 0;
      hold_go <= 1'b1;
      queue_random(40, 70);
      drain_all();

      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("circular_list_deque: match");
      end else begin
         $display("circular_list_deque: mismatch");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("circular_list_deque: mismatch");
      $finish;
   end

endmodule

### files.f
hdl/cld_pkg.sv
hdl/cld_ram.sv
hdl/cld_front.sv
hdl/cld_back.sv
hdl/circular_list_deque.sv
tb/tb_circular_list_deque.sv
